FILE: rtl/jdq_pkg.sv
// Shared constants, types and index helpers for the job deque.
// Used by every file of the job deque; depends on nothing.
`default_nettype none

package jdq_pkg;

  // Sizing of the deque and of the stored tag
  localparam int QUEUE_DEPTH = 32;
  localparam int TAG_BITS    = 16;

  // Fixed widths of the channel fields
  localparam int OPCODE_W = 3;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = 6;

  // Derived widths
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int KEEP_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_GEN  = 3'd0,
    OP_PUSH_URG  = 3'd1,
    OP_PUSH_SYNC = 3'd2,
    OP_DEQUEUE   = 3'd3,
    OP_COMPLETE  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_PAUSED   = 3'd4,
    ST_INVALID  = 3'd5,
    ST_SEQ_ERR  = 3'd6
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GENERIC = 2'd0,
    KIND_URGENT  = 2'd1,
    KIND_SYNC    = 2'd2
  } kind_t;

  // One deque entry
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEEP_W-1:0] tag;
  } slot_t;

  // One result item as it leaves the core
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [KIND_W-1:0]   out_kind;
    logic                requeued;
    logic                release_res;
    logic [ENTRY_W-1:0]  entry_count;
    logic                urgent_pending;
    logic                sync_pending;
  } result_t;

  // Circular index step forward
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  // Circular index step back
  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : IDX_W'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jdq_in_if.sv
// Input channel of the job deque: valid/ready plus one operation.
// Depends on jdq_pkg for field widths.
`default_nettype none

interface jdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [jdq_pkg::OPCODE_W-1:0]  opcode;
  logic [jdq_pkg::TAG_W-1:0]     job_tag;
  logic                          retry;

  modport source (output valid, opcode, job_tag, retry, input ready);
  modport sink   (input valid, opcode, job_tag, retry, output ready);
endinterface

`default_nettype wire

FILE: rtl/jdq_out_if.sv
// Result channel of the job deque: valid/ready plus one result item.
// Depends on jdq_pkg for field widths.
`default_nettype none

interface jdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [jdq_pkg::STATUS_W-1:0]  status;
  logic [jdq_pkg::TAG_W-1:0]     out_tag;
  logic [jdq_pkg::KIND_W-1:0]    out_kind;
  logic                          requeued;
  logic                          release_res;
  logic [jdq_pkg::ENTRY_W-1:0]   entry_count;
  logic                          urgent_pending;
  logic                          sync_pending;

  modport source (output valid, status, out_tag, out_kind, requeued, release_res,
                  entry_count, urgent_pending, sync_pending, input ready);
  modport sink   (input valid, status, out_tag, out_kind, requeued, release_res,
                  entry_count, urgent_pending, sync_pending, output ready);
endinterface

`default_nettype wire

FILE: rtl/jdq_slot_ram.sv
// Slot store of the deque: one write port, one registered read port.
// Depends on jdq_pkg for the entry type and depth.
`default_nettype none

module jdq_slot_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [jdq_pkg::IDX_W-1:0] waddr,
  input  wire jdq_pkg::slot_t            wdata,
  input  wire logic [jdq_pkg::IDX_W-1:0] raddr,
  output jdq_pkg::slot_t                 rdata
);

  jdq_pkg::slot_t mem [jdq_pkg::QUEUE_DEPTH];
  jdq_pkg::slot_t rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read, forwarding a same-cycle write to the read address
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/jdq_core.sv
// Deque state, operation decode and result formation for one operation.
// Depends on jdq_pkg and instantiates jdq_slot_ram.
`default_nettype none

module jdq_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  input  wire logic                         fire,
  input  wire logic [jdq_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [jdq_pkg::TAG_W-1:0]    job_tag,
  input  wire logic                         retry,
  output jdq_pkg::result_t                  res
);

  logic [jdq_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [jdq_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [jdq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      urg_r, urg_nxt;
  logic                      sync_r, sync_nxt;
  logic                      infl_v_r, infl_v_nxt;
  jdq_pkg::slot_t            infl_r, infl_nxt;
  logic                      svc_r;

  logic                      full;
  logic                      wr_en;
  logic [jdq_pkg::IDX_W-1:0] wr_addr;
  jdq_pkg::slot_t            wr_data;
  jdq_pkg::slot_t            head_data;
  logic [jdq_pkg::IDX_W-1:0] rd_addr;
  logic [jdq_pkg::KEEP_W-1:0] tag_keep;
  jdq_pkg::status_t          status;
  logic [jdq_pkg::TAG_W-1:0] otag;
  logic [jdq_pkg::KIND_W-1:0] okind;
  logic                      req;
  logic                      rel;

  assign full     = (count_r == jdq_pkg::CNT_W'(jdq_pkg::QUEUE_DEPTH));
  assign tag_keep = jdq_pkg::KEEP_W'(job_tag);

  // Decode one operation into next state, a slot write and a result
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    urg_nxt    = urg_r;
    sync_nxt   = sync_r;
    infl_v_nxt = infl_v_r;
    infl_nxt   = infl_r;
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    wr_data    = '{kind: jdq_pkg::KIND_GENERIC, tag: tag_keep};
    status     = jdq_pkg::ST_OK;
    otag       = '0;
    okind      = '0;
    req        = 1'b0;
    rel        = 1'b0;
    case (jdq_pkg::opcode_t'(opcode))
      jdq_pkg::OP_PUSH_GEN: begin
        if (tag_keep == '0) begin
          status = jdq_pkg::ST_INVALID;
        end else if (full) begin
          status = jdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = jdq_pkg::idx_next(tail_r);
          count_nxt = count_r + 1'b1;
        end
      end
      jdq_pkg::OP_PUSH_URG: begin
        if (urg_r) begin
          status = jdq_pkg::ST_DUP;
        end else if (full) begin
          status = jdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = jdq_pkg::idx_prev(head_r);
          wr_data   = '{kind: jdq_pkg::KIND_URGENT, tag: '0};
          head_nxt  = jdq_pkg::idx_prev(head_r);
          count_nxt = count_r + 1'b1;
          urg_nxt   = 1'b1;
        end
      end
      jdq_pkg::OP_PUSH_SYNC: begin
        if (sync_r) begin
          status = jdq_pkg::ST_DUP;
        end else if (full) begin
          status = jdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_data   = '{kind: jdq_pkg::KIND_SYNC, tag: '0};
          tail_nxt  = jdq_pkg::idx_next(tail_r);
          count_nxt = count_r + 1'b1;
          sync_nxt  = 1'b1;
        end
      end
      jdq_pkg::OP_DEQUEUE: begin
        if (infl_v_r) begin
          status = jdq_pkg::ST_SEQ_ERR;
        end else if (!svc_r) begin
          status = jdq_pkg::ST_PAUSED;
        end else if (count_r == '0) begin
          status = jdq_pkg::ST_EMPTY;
        end else begin
          infl_nxt   = head_data;
          infl_v_nxt = 1'b1;
          head_nxt   = jdq_pkg::idx_next(head_r);
          count_nxt  = count_r - 1'b1;
          otag       = jdq_pkg::TAG_W'(head_data.tag);
          okind      = head_data.kind;
        end
      end
      jdq_pkg::OP_COMPLETE: begin
        if (!infl_v_r) begin
          status = jdq_pkg::ST_SEQ_ERR;
        end else begin
          infl_v_nxt = 1'b0;
          otag       = jdq_pkg::TAG_W'(infl_r.tag);
          okind      = infl_r.kind;
          if (retry && !full) begin
            // Requeue: urgent at the head, anything else at the tail
            wr_en     = 1'b1;
            wr_data   = infl_r;
            count_nxt = count_r + 1'b1;
            req       = 1'b1;
            if (infl_r.kind == jdq_pkg::KIND_URGENT) begin
              wr_addr  = jdq_pkg::idx_prev(head_r);
              head_nxt = jdq_pkg::idx_prev(head_r);
            end else begin
              tail_nxt = jdq_pkg::idx_next(tail_r);
            end
          end else begin
            // Finished or could not requeue: drop the pending flag
            rel = 1'b1;
            if (infl_r.kind == jdq_pkg::KIND_URGENT) begin
              urg_nxt = 1'b0;
            end else if (infl_r.kind == jdq_pkg::KIND_SYNC) begin
              sync_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        status = jdq_pkg::ST_SEQ_ERR;
      end
    endcase
  end

  // Form the result item
  always_comb begin
    res.status         = status;
    res.out_tag        = otag;
    res.out_kind       = okind;
    res.requeued       = req;
    res.release_res    = rel;
    res.entry_count    = jdq_pkg::ENTRY_W'(count_nxt);
    res.urgent_pending = urg_nxt;
    res.sync_pending   = sync_nxt;
  end

  // Advance the control state on each processed operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      urg_r    <= 1'b0;
      sync_r   <= 1'b0;
      infl_v_r <= 1'b0;
      infl_r   <= '0;
    end else if (fire) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      urg_r    <= urg_nxt;
      sync_r   <= sync_nxt;
      infl_v_r <= infl_v_nxt;
      infl_r   <= infl_nxt;
    end
  end

  // Hold the service enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_r <= 1'b0;
    end else if (cfg_we) begin
      svc_r <= cfg_wdata;
    end
  end

  // Keep the read port pointed at the head the next operation will see
  assign rd_addr = fire ? head_nxt : head_r;

  jdq_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (fire && wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (head_data)
  );

endmodule

`default_nettype wire

FILE: rtl/job_deque_with_dedup_retry.sv
// Top level of the job deque: input register, core and result register.
// Depends on jdq_pkg, jdq_in_if, jdq_out_if and jdq_core.
//
//  channel | direction | transfer when          | payload
//  in_ch   | in        | valid && ready         | opcode, job_tag, retry
//  out_ch  | out       | valid && ready         | status, out_tag, out_kind, requeued,
//          |           |                        | release_res, entry_count, pending flags
//  cfg     | in        | cfg_we high            | cfg_wdata (service enable)
//
// One operation per cycle sustained while results are taken; a result is offered
// once its input has passed the input register, the core and the result register.
// The head entry is prefetched from the slot store, so dequeue never waits on a read.
// Synchronous reset on rst_n clears pointers, count, flags and the in-flight slot.
// A stalled result holds the result register; the input register takes a new
// operation whenever the result register moves or is empty.
`default_nettype none

module job_deque_with_dedup_retry (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jdq_in_if.sink     in_ch,
  jdq_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  logic                         in_valid_r;
  logic [jdq_pkg::OPCODE_W-1:0] in_opcode_r;
  logic [jdq_pkg::TAG_W-1:0]    in_tag_r;
  logic                         in_retry_r;
  logic                         out_valid_r;
  jdq_pkg::result_t             out_r;
  jdq_pkg::result_t             core_res;
  logic                         fire;
  logic                         in_ready;

  // Process the held operation when the result register can take it
  assign fire     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || fire;
  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_opcode_r <= in_ch.opcode;
      in_tag_r    <= in_ch.job_tag;
      in_retry_r  <= in_ch.retry;
    end
  end

  jdq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .opcode    (in_opcode_r),
    .job_tag   (in_tag_r),
    .retry     (in_retry_r),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.out_tag        = out_r.out_tag;
  assign out_ch.out_kind       = out_r.out_kind;
  assign out_ch.requeued       = out_r.requeued;
  assign out_ch.release_res    = out_r.release_res;
  assign out_ch.entry_count    = out_r.entry_count;
  assign out_ch.urgent_pending = out_r.urgent_pending;
  assign out_ch.sync_pending   = out_r.sync_pending;

  // Input side only backs up while a full input register waits on a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a stalled result");

  // A job is either requeued or released, never both
  a_req_rel_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.requeued && out_r.release_res))
    else $error("requeued and release_res both set");

  // Refused operations carry no job
  a_refused_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != jdq_pkg::ST_OK)) |->
      ((out_r.out_tag == '0) && (out_r.out_kind == '0) &&
       !out_r.requeued && !out_r.release_res))
    else $error("refused operation reports a job");

  // Queue occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.entry_count <= jdq_pkg::ENTRY_W'(jdq_pkg::QUEUE_DEPTH)))
    else $error("entry count beyond queue depth");

endmodule

`default_nettype wire
